// File: sv/rmed_pkg.sv
// rmed_pkg: shared widths and defaults for the running median block.
// Depends on nothing; imported by rmed_cell, rmed_tree and running_median_core.
`timescale 1ns / 1ps

package rmed_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int GROUP_N       = 8;

endpackage

// File: sv/rmed_cell.sv
// rmed_cell: one slot of the sorted insertion chain, holds one sample.
// Depends on rmed_pkg; instantiated in a row by running_median_core.
`timescale 1ns / 1ps

module rmed_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int IW  = 6
) (
  input  logic                                clk,
  input  logic                                ins,
  input  logic signed [rmed_pkg::SAMPLE_W-1:0] smp,
  input  logic [CW-1:0]                       cnt_eff,
  input  logic [IW-1:0]                       med_idx,
  input  logic signed [rmed_pkg::SAMPLE_W-1:0] left_val,
  input  logic                                left_gt,
  output logic signed [rmed_pkg::SAMPLE_W-1:0] val,
  output logic                                gt,
  output logic [rmed_pkg::SAMPLE_W-1:0]       tap
);
  import rmed_pkg::*;

  logic signed [SAMPLE_W-1:0] val_r;
  logic signed [SAMPLE_W-1:0] val_nxt;
  logic                       occ;
  logic                       at_end;

  assign occ    = (CW'(IDX) < cnt_eff);
  assign at_end = (CW'(IDX) == cnt_eff);
  assign gt     = occ && (val_r > smp);
  assign val    = val_r;
  assign tap    = (med_idx == IW'(IDX)) ? val_r : '0;

  always_comb begin
    val_nxt = val_r;
    if (ins && (gt || at_end)) begin
      val_nxt = left_gt ? left_val : smp;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: sv/rmed_tree.sv
// rmed_tree: registered OR tree that collects the selected cell value.
// Depends on rmed_pkg; used by running_median_core.
`timescale 1ns / 1ps

module rmed_tree #(
  parameter int N = rmed_pkg::MAX_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          ld,
  input  logic [rmed_pkg::SAMPLE_W-1:0] taps [N],
  output logic [rmed_pkg::SAMPLE_W-1:0] res
);
  import rmed_pkg::*;

  localparam int NG = (N + GROUP_N - 1) / GROUP_N;

  logic [SAMPLE_W-1:0] grp_r   [NG];
  logic [SAMPLE_W-1:0] grp_nxt [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP_N; k++) begin
        if (g * GROUP_N + k < N) begin
          grp_nxt[g] = grp_nxt[g] | taps[g * GROUP_N + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      grp_r <= grp_nxt;
    end
  end

  always_comb begin
    res = '0;
    for (int g = 0; g < NG; g++) begin
      res = res | grp_r[g];
    end
  end

endmodule

// File: sv/running_median_core.sv
// running_median_core: streaming lower median over a sorted chain of cells.
// Depends on rmed_pkg, rmed_cell and rmed_tree.
//
//   channel   ports                          direction
//   in        in_valid/in_ready, in_sample,  request into the block
//             in_first
//   out       out_valid/out_ready,           result out of the block
//             out_median, out_full_res
//
// Each request passes three steps in turn: insert into the chain, registered OR over groups
// of cells, final OR into the output register. The output register lets the
// next request enter while a result waits. A stalled output holds the third
// stage. Reset clears the fill count and control; cell values need no reset.
`timescale 1ns / 1ps

module running_median_core #(
  parameter int MAX_ITEMS = rmed_pkg::MAX_ITEMS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rmed_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_first,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rmed_pkg::SAMPLE_W-1:0] out_median,
  output logic                                 out_full_res
);
  import rmed_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = $clog2(MAX_ITEMS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_GRP  = 3'b010,
    ST_RED  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cnt_eff;
  logic [CW-1:0]        cnt_new;
  logic [IW-1:0]        med_idx_r;
  logic                 full_r;
  logic                 full_now;
  logic                 acc;
  logic                 out_ld;
  logic                 out_valid_r;
  logic signed [SAMPLE_W-1:0] out_median_r;
  logic                 out_full_r;

  logic signed [SAMPLE_W-1:0] cval [MAX_ITEMS];
  logic                       cgt  [MAX_ITEMS];
  logic [SAMPLE_W-1:0]        ctap [MAX_ITEMS];
  logic [SAMPLE_W-1:0]        tree_res;

  assign in_ready     = (state_r == ST_IDLE);
  assign acc          = in_valid && in_ready;
  assign cnt_eff      = in_first ? '0 : cnt_r;
  assign full_now     = (cnt_eff == CW'(MAX_ITEMS));
  assign cnt_new      = full_now ? cnt_eff : cnt_eff + CW'(1);
  assign out_ld       = (state_r == ST_RED) && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign out_median   = out_median_r;
  assign out_full_res = out_full_r;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rmed_cell #(
      .IDX (i),
      .CW  (CW),
      .IW  (IW)
    ) u_cell (
      .clk      (clk),
      .ins      (acc && !full_now),
      .smp      (in_sample),
      .cnt_eff  (cnt_eff),
      .med_idx  (med_idx_r),
      .left_val ((i == 0) ? '0 : cval[(i == 0) ? 0 : i - 1]),
      .left_gt  ((i == 0) ? 1'b0 : cgt[(i == 0) ? 0 : i - 1]),
      .val      (cval[i]),
      .gt       (cgt[i]),
      .tap      (ctap[i])
    );
  end

  rmed_tree #(
    .N (MAX_ITEMS)
  ) u_tree (
    .clk  (clk),
    .ld   (state_r == ST_GRP),
    .taps (ctap),
    .res  (tree_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) state_nxt = ST_GRP;
      end
      ST_GRP: begin
        state_nxt = ST_RED;
      end
      ST_RED: begin
        if (out_ld) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        cnt_r <= cnt_new;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      med_idx_r <= IW'((cnt_new - CW'(1)) >> 1);
      full_r    <= full_now;
    end
    if (out_ld) begin
      out_median_r <= tree_res;
      out_full_r   <= full_r;
    end
  end

endmodule

// File: sim/tb_running_median_core.sv
// tb_running_median_core: checks running_median_core against a sorted-store predictor,
// with random gaps on both valid/ready channels. Depends on rmed_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_running_median_core;

  localparam int W     = rmed_pkg::SAMPLE_W;
  localparam int DEPTH = rmed_pkg::MAX_ITEMS_DEF;
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [W-1:0] in_sample = '0;
  logic                in_first = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [W-1:0] out_median;
  logic                out_full_res;

  logic signed [W-1:0] held [DEPTH];
  int unsigned         held_n = 0;
  logic signed [W-1:0] median_q [$];
  logic                full_q [$];
  int                  errors = 0;
  bit                  idling = 1'b1;

  running_median_core #(.MAX_ITEMS(DEPTH)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_first    (in_first),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_median  (out_median),
    .out_full_res(out_full_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function void insert_and_predict(input logic signed [W-1:0] s, input logic f);
    int  pos;
    logic drop;
    if (f) held_n = 0;
    drop = (held_n >= DEPTH);
    if (!drop) begin
      pos = held_n;
      while (pos > 0 && held[pos-1] > s) begin
        held[pos] = held[pos-1];
        pos--;
      end
      held[pos] = s;
      held_n++;
    end
    median_q.push_back(held[(held_n - 1) / 2]);
    full_q.push_back(drop);
  endfunction

  function automatic logic signed [W-1:0] pick_sample();
    logic signed [W-1:0] v;
    case ($urandom_range(0, 9)) inside
      [0:3]:   v = $urandom;
      [4:6]:   v = $signed($urandom_range(0, 16)) - 8;
      7:       v = SMIN + $urandom_range(0, 3);
      8:       v = SMAX - $urandom_range(0, 3);
      default: v = (held_n > 0) ? held[$urandom_range(0, held_n - 1)] : $urandom;
    endcase
    return v;
  endfunction

  task automatic send_request(input logic signed [W-1:0] s, input logic f);
    int gap;
    gap = idling ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_first  <= f;
    do @(posedge clk); while (!in_ready);
    insert_and_predict(s, f);
  endtask

  task automatic test_directed();
    send_request(32'sd5, 1'b0);
    send_request(SMAX, 1'b0);
    send_request(SMIN, 1'b0);
    send_request(-32'sd1, 1'b0);
    send_request(32'sd0, 1'b0);
    send_request(SMIN, 1'b1);
    send_request(SMIN, 1'b0);
    send_request(SMAX, 1'b0);
    send_request(SMAX, 1'b0);
    send_request(32'sd7, 1'b1);
    send_request(32'sd7, 1'b0);
    send_request(32'sd7, 1'b0);
    send_request(-32'sd7, 1'b0);
    send_request(32'sd7, 1'b0);
    send_request(32'sh5555_5555, 1'b1);
    send_request(32'shAAAA_AAAA, 1'b0);
    send_request(32'sd0, 1'b0);
    send_request(SMAX, 1'b1);
    send_request(SMIN, 1'b1);
    send_request(-32'sd1, 1'b1);
  endtask

  task automatic test_store_full();
    int i;
    for (i = 0; i < DEPTH; i++)
      send_request(SMAX - i, i == 0);
    for (i = 0; i < 5; i++)
      send_request(pick_sample(), 1'b0);
    send_request(32'sd3, 1'b1);
    send_request(-32'sd3, 1'b0);
    for (i = 0; i < DEPTH + 2; i++)
      send_request(pick_sample(), 1'b0);
    send_request(SMIN, 1'b1);
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int len;
    int i;
    sent = 0;
    while (sent < n_items) begin
      idling = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(DEPTH - 10, DEPTH + 12)
                                        : $urandom_range(1, 20);
      for (i = 0; i < len; i++) begin
        send_request(pick_sample(), (i == 0) || ($urandom_range(0, 40) == 0));
        sent++;
      end
    end
    idling = 1'b1;
  endtask

  initial begin
    int                  stall;
    logic signed [W-1:0] exp_med;
    logic                exp_full;
    wait (rst_n);
    forever begin
      stall = idling ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (median_q.size() == 0) begin
        $error("out_median %0d arrived with no request pending", out_median);
        errors++;
      end else begin
        exp_med  = median_q.pop_front();
        exp_full = full_q.pop_front();
        if (out_median !== exp_med) begin
          $error("median mismatch: expected %0d, got %0d", exp_med, out_median);
          errors++;
        end
        if (out_full_res !== exp_full) begin
          $error("full_res mismatch: expected %0d, got %0d", exp_full, out_full_res);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random(490);
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
